// ===== src/held_note_priority_stack_assert.svh =====
// Assertion macros of the held note priority stack RTL.
`ifndef HELD_NOTE_PRIORITY_STACK_ASSERT_SVH
`define HELD_NOTE_PRIORITY_STACK_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define HNPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define HNPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/hnps_pkg.sv =====
// Package with types and constants of the held note priority stack.
package hnps_pkg;

  localparam int HNPS_SLOTS = 16;

  // One held note as stored in a cell.
  typedef struct packed {
    logic       vld;
    logic [6:0] pitch;
    logic [6:0] vel;
  } hnps_note_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_KILL,
    CELL_COMPACT,
    CELL_SHIFT
  } hnps_cell_op_t;

  // Command broadcast to every cell.
  typedef struct packed {
    hnps_cell_op_t op;
    logic [6:0]    key;
  } hnps_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_COMPACT,
    ST_EVICT,
    ST_INSERT,
    ST_SCAN,
    ST_DONE
  } hnps_state_t;

  typedef enum logic [1:0] {
    MODE_NEWEST  = 2'd0,
    MODE_LOWEST  = 2'd1,
    MODE_HIGHEST = 2'd2,
    MODE_NONE    = 2'd3
  } hnps_mode_t;

  localparam logic ACT_PRESS = 1'b0;

endpackage

// ===== src/hnps_if.sv =====
// Handshake interfaces for the event, result and configuration channels.
interface hnps_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [6:0] pitch;
  logic [6:0] strike;
  modport source (output valid, action, pitch, strike, input ready);
  modport sink (input valid, action, pitch, strike, output ready);
endinterface

interface hnps_out_if;
  logic       valid;
  logic       ready;
  logic       trigger_valid;
  logic [6:0] trigger_pitch;
  logic [6:0] trigger_velocity;
  logic [4:0] held_count;
  modport source (output valid, trigger_valid, trigger_pitch, trigger_velocity, held_count,
                  input ready);
  modport sink (input valid, trigger_valid, trigger_pitch, trigger_velocity, held_count,
                output ready);
endinterface

interface hnps_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] priority_mode;
  modport source (output valid, priority_mode, input ready);
  modport sink (input valid, priority_mode, output ready);
endinterface

// ===== src/hnps_cell.sv =====
// One cell of the recency chain: holds a single note and trades with its neighbors.
module hnps_cell import hnps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  hnps_ctrl_t ctrl,
  input  hnps_note_t newer_i,
  input  hnps_note_t older_i,
  output hnps_note_t note_o
);

  hnps_note_t note_r;
  hnps_note_t note_nxt;

  // Apply the broadcast command to this cell.
  always_comb begin
    note_nxt = note_r;
    case (ctrl.op)
      CELL_KILL: begin
        if (note_r.vld && note_r.pitch == ctrl.key) note_nxt.vld = 1'b0;
      end
      CELL_COMPACT: begin
        // An empty cell pulls the older note up; a note under an empty cell leaves.
        if (!note_r.vld) begin
          note_nxt = older_i;
        end else if (!newer_i.vld) begin
          note_nxt.vld = 1'b0;
        end
      end
      CELL_SHIFT: begin
        note_nxt = newer_i;
      end
      default: begin
      end
    endcase
  end

  // The whole note is cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      note_r <= '0;
    end else begin
      note_r <= note_nxt;
    end
  end

  assign note_o = note_r;

endmodule

// ===== src/held_note_priority_stack.sv =====
// Top level of the held note priority stack: cell chain, sequencer and selection scan.
//
//   channel | dir | transaction
//   in_ch   | in  | one note event: action, pitch, strike
//   out_ch  | out | one result: trigger_valid, trigger_pitch, trigger_velocity, held_count
//   cfg_ch  | in  | write of priority_mode
//
// A press goes from acceptance through a match state, the compaction states in which a
// gap moves one cell per cycle, an eviction state, an insert state and a scan over the
// cells before its result is offered. A release skips eviction and insert.
// Reset (rst_n low, synchronous) empties every cell and forgets the sounded note.
// A stalled result holds; the next event is taken in the cycle after the result transaction.
module held_note_priority_stack import hnps_pkg::*; #(
  parameter int SLOTS = HNPS_SLOTS
) (
  input  logic clk,
  input  logic rst_n,
  hnps_in_if.sink    in_ch,
  hnps_out_if.source out_ch,
  hnps_cfg_if.sink   cfg_ch
);

`include "held_note_priority_stack_assert.svh"

  localparam int CW = $clog2(SLOTS + 1);
  localparam int IW = $clog2(SLOTS);

  hnps_state_t state_r, state_nxt;
  hnps_ctrl_t  ctrl;
  hnps_note_t  notes [SLOTS];
  hnps_note_t  fresh;
  logic [SLOTS-1:0] match_vec;
  logic        any_match;
  logic        full;

  logic          act_r;
  logic [6:0]    pitch_r, vel_r;
  logic [1:0]    mode_r;
  logic [CW-1:0] count_r;
  logic [IW-1:0] idx_r;
  logic          last_vld_r;
  logic [6:0]    last_pitch_r;
  logic          best_vld_r;
  logic [6:0]    best_pitch_r, best_vel_r;
  logic          trig_r;
  logic [6:0]    trig_pitch_r, trig_vel_r;
  logic          take;
  hnps_note_t    sel;
  logic          idx_end;
  logic [6:0]    win_pitch, win_vel;
  logic          fire;

  assign fresh     = '{vld: 1'b1, pitch: pitch_r, vel: vel_r};
  assign full      = (count_r == CW'(SLOTS));
  assign idx_end   = (idx_r == IW'(SLOTS - 1));
  assign sel       = notes[idx_r];

  // The chain of cells, newest note in cell 0.
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    hnps_note_t newer, older;
    if (g == 0) begin : g_first
      assign newer = fresh;
    end else begin : g_mid
      assign newer = notes[g-1];
    end
    if (g == SLOTS - 1) begin : g_last
      assign older = '0;
    end else begin : g_inner
      assign older = notes[g+1];
    end
    hnps_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .newer_i (newer),
      .older_i (older),
      .note_o  (notes[g])
    );
    assign match_vec[g] = notes[g].vld && notes[g].pitch == pitch_r;
  end

  assign any_match = |match_vec;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_ch.valid) state_nxt = ST_MATCH;
      ST_MATCH:   state_nxt = ST_COMPACT;
      ST_COMPACT: if (idx_end) state_nxt = (act_r == ACT_PRESS) ? ST_EVICT : ST_SCAN;
      ST_EVICT:   state_nxt = ST_INSERT;
      ST_INSERT:  state_nxt = ST_SCAN;
      ST_SCAN:    if (idx_end) state_nxt = ST_DONE;
      ST_DONE:    if (out_ch.ready) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Cell commands.
  always_comb begin
    ctrl = '{op: CELL_HOLD, key: pitch_r};
    unique case (state_r)
      ST_MATCH:   ctrl.op = CELL_KILL;
      ST_COMPACT: ctrl.op = CELL_COMPACT;
      ST_EVICT: begin
        ctrl.key = notes[SLOTS-1].pitch;
        if (full) ctrl.op = CELL_KILL;
      end
      ST_INSERT:  ctrl.op = CELL_SHIFT;
      default:    ctrl.op = CELL_HOLD;
    endcase
  end

  // A scanned cell replaces the best so far according to the priority mode.
  always_comb begin
    take = 1'b0;
    if (sel.vld) begin
      case (hnps_mode_t'(mode_r))
        MODE_NEWEST:  take = (idx_r == '0);
        MODE_LOWEST:  take = !best_vld_r || sel.pitch < best_pitch_r;
        MODE_HIGHEST: take = !best_vld_r || sel.pitch > best_pitch_r;
        default:      take = 1'b0;
      endcase
    end
  end

  // Winner of the scan and whether it differs from the note already sounding.
  assign win_pitch = take ? sel.pitch : best_pitch_r;
  assign win_vel   = take ? sel.vel : best_vel_r;
  assign fire      = (take || best_vld_r) && !(last_vld_r && last_pitch_r == win_pitch);

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      count_r    <= '0;
      idx_r      <= '0;
      mode_r     <= MODE_NEWEST;
      last_vld_r <= 1'b0;
      best_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) mode_r <= cfg_ch.priority_mode;
      case (state_r)
        ST_IDLE: begin
          idx_r      <= '0;
          best_vld_r <= 1'b0;
        end
        ST_MATCH: begin
          if (any_match) count_r <= count_r - CW'(1);
          if (last_vld_r && last_pitch_r == pitch_r) last_vld_r <= 1'b0;
        end
        ST_COMPACT: idx_r <= idx_end ? '0 : idx_r + IW'(1);
        ST_EVICT: begin
          if (full) begin
            count_r <= count_r - CW'(1);
            if (last_vld_r && last_pitch_r == notes[SLOTS-1].pitch) last_vld_r <= 1'b0;
          end
        end
        ST_INSERT: count_r <= count_r + CW'(1);
        ST_SCAN: begin
          idx_r <= idx_end ? '0 : idx_r + IW'(1);
          if (take) best_vld_r <= 1'b1;
          // Result is decided here; the sounded note is remembered at once.
          if (idx_end && fire) last_vld_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      act_r   <= in_ch.action;
      pitch_r <= in_ch.pitch;
      vel_r   <= in_ch.strike;
    end
    if (state_r == ST_SCAN && take) begin
      best_pitch_r <= sel.pitch;
      best_vel_r   <= sel.vel;
    end
    if (state_r == ST_SCAN && idx_end) begin
      trig_r       <= fire;
      trig_pitch_r <= fire ? win_pitch : '0;
      trig_vel_r   <= fire ? win_vel : '0;
      if (fire) last_pitch_r <= win_pitch;
    end
  end

  assign out_ch.valid            = (state_r == ST_DONE);
  assign out_ch.trigger_valid    = trig_r;
  assign out_ch.trigger_pitch    = trig_pitch_r;
  assign out_ch.trigger_velocity = trig_vel_r;
  assign out_ch.held_count       = 5'(count_r);

  // Checks on the sequencer and the bookkeeping.
  `HNPS_ASSERT_NOW(a_count_range, 1'b1, count_r <= CW'(SLOTS), "held count above slot count")
  `HNPS_ASSERT_NOW(a_trig_has_note, out_ch.valid && trig_r, count_r != '0,
                   "trigger reported with no note held")
  `HNPS_ASSERT_NEXT(a_insert_fills, state_r == ST_INSERT,
                    notes[0].vld && notes[0].pitch == pitch_r,
                    "inserted note missing from the newest cell")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench of the held note priority stack with its scoreboard class.
`timescale 1ns / 1ps

import hnps_pkg::*;

typedef struct {
  logic       trig;
  logic [6:0] pitch;
  logic [6:0] vel;
  logic [4:0] held;
} note_result_t;

// Tracks the held notes, predicts each result and checks the block's results in order.
class note_scoreboard;
  localparam int NSLOT = HNPS_SLOTS;
  localparam logic [7:0] NO_NOTE = 8'hFF;

  hnps_mode_t   mode;
  logic [7:0]   cell_pitch [NSLOT+1];
  logic [6:0]   cell_vel [NSLOT+1];
  int           older [NSLOT+1];
  int           by_pitch [NSLOT];
  int           newest;
  int           held;
  logic [7:0]   sounding;
  note_result_t pending_q [$];
  int           errors;

  function void clear();
    mode = MODE_NEWEST;
    for (int i = 0; i <= NSLOT; i++) begin
      cell_pitch[i] = NO_NOTE;
      cell_vel[i] = '0;
      older[i] = 0;
    end
    for (int i = 0; i < NSLOT; i++) by_pitch[i] = 0;
    newest = 0;
    held = 0;
    sounding = NO_NOTE;
    pending_q.delete();
    errors = 0;
  endfunction

  function void set_mode(hnps_mode_t m);
    mode = m;
  endfunction

  // Unlinks a pitch from the recency chain and closes its gap in the pitch order.
  function void unlink(logic [7:0] p);
    int cur;
    int prev;
    int steps;
    bit found;
    cur = newest;
    prev = 0;
    steps = 0;
    found = 0;
    while (cur != 0 && cur <= NSLOT && steps < NSLOT) begin
      if (cell_pitch[cur] == p) begin
        found = 1;
        break;
      end
      prev = cur;
      cur = older[cur];
      steps++;
    end
    if (found) begin
      if (prev != 0) older[prev] = older[cur];
      else newest = older[cur];
      for (int i = 0; i < held && i < NSLOT; i++) begin
        if (by_pitch[i] == cur) begin
          for (int j = i; j + 1 < held && j + 1 < NSLOT; j++) by_pitch[j] = by_pitch[j+1];
          break;
        end
      end
      older[cur] = 0;
      cell_pitch[cur] = NO_NOTE;
      cell_vel[cur] = '0;
      if (held > 0) held--;
    end
    if (p == sounding) sounding = NO_NOTE;
  endfunction

  // Stores a press, evicting the oldest note when the table is full.
  function void store(logic [7:0] p, logic [6:0] v);
    logic [7:0] oldest;
    int free_cell;
    int pos;
    int s;
    unlink(p);
    if (held >= NSLOT) begin
      oldest = 8'd1;
      for (int i = 1; i <= NSLOT; i++) if (older[i] == 0) oldest = cell_pitch[i];
      unlink(oldest);
    end
    if (held >= NSLOT) return;
    free_cell = 1;
    for (int i = 1; i <= NSLOT; i++) begin
      if (cell_pitch[i] == NO_NOTE) begin
        free_cell = i;
        break;
      end
    end
    older[free_cell] = newest;
    cell_pitch[free_cell] = p;
    cell_vel[free_cell] = v;
    newest = free_cell;
    pos = held;
    for (int i = 0; i < held; i++) begin
      s = by_pitch[i];
      if (s <= NSLOT && cell_pitch[s] != NO_NOTE && cell_pitch[s] > p) begin
        pos = i;
        break;
      end
    end
    for (int i = held; i > pos; i--) by_pitch[i] = by_pitch[i-1];
    by_pitch[pos] = free_cell;
    held++;
  endfunction

  // Applies one accepted event and queues the result it must produce.
  function void note_event(logic act, logic [6:0] p, logic [6:0] v);
    note_result_t r;
    int pick;
    bit have;
    if (act == ACT_PRESS) store({1'b0, p}, v);
    else unlink({1'b0, p});
    pick = 0;
    have = 0;
    if (held > 0) begin
      case (mode)
        MODE_NEWEST: begin
          pick = newest;
          have = 1;
        end
        MODE_LOWEST: begin
          pick = by_pitch[0];
          have = 1;
        end
        MODE_HIGHEST: begin
          pick = by_pitch[(held - 1) % NSLOT];
          have = 1;
        end
        default: have = 0;
      endcase
    end
    if (pick > NSLOT) have = 0;
    r.trig = 1'b0;
    r.pitch = '0;
    r.vel = '0;
    if (have && cell_pitch[pick] != NO_NOTE && cell_pitch[pick] != sounding) begin
      sounding = cell_pitch[pick];
      r.trig = 1'b1;
      r.pitch = cell_pitch[pick][6:0];
      r.vel = cell_vel[pick];
    end
    r.held = held[4:0];
    pending_q.push_back(r);
  endfunction

  // Compares one result with the oldest expectation.
  function void check_result(note_result_t got);
    note_result_t exp;
    if (pending_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result trig=%0b pitch=%0d vel=%0d held=%0d",
               $time, got.trig, got.pitch, got.vel, got.held);
      return;
    end
    exp = pending_q.pop_front();
    if (exp.trig !== got.trig || exp.pitch !== got.pitch || exp.vel !== got.vel ||
        exp.held !== got.held) begin
      errors++;
      if (errors <= 30)
        $display("%0t: expected trig=%0b pitch=%0d vel=%0d held=%0d,",
                 $time, exp.trig, exp.pitch, exp.vel, exp.held,
                 " got trig=%0b pitch=%0d vel=%0d held=%0d",
                 got.trig, got.pitch, got.vel, got.held);
    end
  endfunction

  function int waiting();
    return pending_q.size();
  endfunction
endclass

module testbench;
  localparam logic ACT_RELEASE = ~ACT_PRESS;
  localparam int DRAIN_CYCLES = 2 * HNPS_SLOTS + 12;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int PHASE_ITEMS = 205;

  logic clk;
  logic rst_n;
  int   cycles;
  int   snd_idle;
  int   rcv_idle;
  int   rcv_hold;
  int   base;
  note_scoreboard notes;
  note_result_t   seen;

  hnps_in_if  in_ch();
  hnps_out_if out_ch();
  hnps_cfg_if cfg_ch();

  held_note_priority_stack u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Cycle counter with the run's timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("held_note_priority_stack: mismatch");
      $finish;
    end
  end

  // Result ready, with random idling and a long hold-off on request.
  always @(posedge clk) begin
    if (rcv_hold > 0) begin
      rcv_hold <= rcv_hold - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // Transaction monitors feeding the scoreboard.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) notes.set_mode(hnps_mode_t'(cfg_ch.priority_mode));
      if (in_ch.valid && in_ch.ready) notes.note_event(in_ch.action, in_ch.pitch, in_ch.strike);
      if (out_ch.valid && out_ch.ready) begin
        seen.trig = out_ch.trigger_valid;
        seen.pitch = out_ch.trigger_pitch;
        seen.vel = out_ch.trigger_velocity;
        seen.held = out_ch.held_count;
        notes.check_result(seen);
      end
    end
  end

  task automatic send_event(logic act, logic [6:0] p, logic [6:0] v);
    while ($urandom_range(99) < snd_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.pitch <= p;
    in_ch.strike <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // One edge passes first so the monitor has noted the last accepted event.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (notes.waiting() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes the priority mode once the block is idle.
  task automatic write_mode(hnps_mode_t m);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.priority_mode <= m;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly presses and releases over a narrow pitch window, so notes get re-hit.
  task automatic random_event();
    logic [6:0] p;
    if ($urandom_range(99) < 85) p = 7'(base + $urandom_range(23));
    else p = 7'($urandom_range(127));
    send_event(($urandom_range(99) < 55) ? ACT_PRESS : ACT_RELEASE, p, 7'($urandom_range(127)));
  endtask

  initial begin
    hnps_mode_t phase_mode [6];
    notes = new();
    notes.clear();
    phase_mode = '{MODE_LOWEST, MODE_HIGHEST, MODE_NONE, MODE_NEWEST, MODE_HIGHEST, MODE_LOWEST};
    cycles = 0;
    snd_idle = 0;
    rcv_idle = 0;
    rcv_hold = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_PRESS;
    in_ch.pitch = '0;
    in_ch.strike = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.priority_mode = MODE_NEWEST;
    out_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: pitch and velocity extremes, re-press and release of the sounded
    // note, release of a note not held, release of the last held note.
    send_event(ACT_PRESS, 7'd60, 7'd127);
    send_event(ACT_PRESS, 7'd60, 7'd0);
    send_event(ACT_PRESS, 7'd0, 7'd1);
    send_event(ACT_PRESS, 7'd127, 7'd126);
    send_event(ACT_RELEASE, 7'd127, 7'd127);
    send_event(ACT_RELEASE, 7'd5, 7'd0);
    send_event(ACT_RELEASE, 7'd0, 7'd0);
    send_event(ACT_RELEASE, 7'd60, 7'd0);
    // Overfill the table so the oldest note is evicted.
    for (int i = 0; i < 17; i++) send_event(ACT_PRESS, 7'(10 + i), 7'(i * 7));

    // Random phases over every priority mode and idling pattern.
    for (int ph = 0; ph < 6; ph++) begin
      write_mode(phase_mode[ph]);
      snd_idle = (ph < 2) ? 24 : (ph < 4) ? 85 : 0;
      rcv_idle = (ph < 2) ? 85 : (ph < 4) ? 24 : 0;
      base = $urandom_range(104);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 0 && n == 40) rcv_hold = 400;
        if (ph == 2 && n == 100) wait_drained();
        if (n % 50 == 49) base = $urandom_range(104);
        random_event();
      end
    end

    wait_drained();
    if (notes.errors == 0) $display("held_note_priority_stack: match");
    else $display("held_note_priority_stack: mismatch");
    $finish;
  end
endmodule
